FILE: src/lsnh_pkg.sv
// Package with the types, widths and arithmetic helpers of the nearest line-sphere hit block.
`timescale 1ns / 1ps
package lsnh_pkg;

    localparam int COORD_W   = 24;
    localparam int R_W       = 22;
    localparam int DIFF_W    = 25;
    localparam int PROD_W    = 50;
    localparam int SQ_W      = 50;
    localparam int DOT_W     = 51;
    localparam int R2_W      = 44;
    localparam int SPLIT_W   = 26;
    localparam int OPND_W    = 2 * SPLIT_W;
    localparam int WIDE_W    = 4 * SPLIT_W;
    localparam int DISC_W    = 102;
    localparam int ROOT_W    = DISC_W / 2;
    localparam int REM_W     = ROOT_W + 2;
    localparam int NSQ_W     = 102;
    localparam int DIST_W    = 24;
    localparam int P_W       = 104;
    localparam int Q_W       = 74;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] start_z;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] end_z;
    } lsnh_in_t;

    typedef struct packed {
        logic [DIST_W-1:0] near_distance;
        logic              no_hit;
    } lsnh_out_t;

    typedef struct packed {
        logic [OPND_W-1:0] hh;
        logic [OPND_W-1:0] hl;
        logic [OPND_W-1:0] lh;
        logic [OPND_W-1:0] ll;
    } lsnh_pp_t;

    typedef struct packed {
        logic              valid;
        logic              no_hit;
        logic [SQ_W-1:0]   babs;
        logic [SQ_W-1:0]   bsq;
        logic [DISC_W-1:0] disc;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } lsnh_sqrt_t;

    typedef struct packed {
        logic              valid;
        logic              no_hit;
        logic [SQ_W-1:0]   bsq;
        logic [NSQ_W-1:0]  nsq;
        logic [P_W-1:0]    p;
        logic [Q_W-1:0]    q;
        logic [DIST_W-1:0] r;
    } lsnh_dist_t;

    // Four partial products of two operands split into halves of SPLIT_W bits.
    function automatic lsnh_pp_t pp_split(input logic [OPND_W-1:0] a, input logic [OPND_W-1:0] b);
        lsnh_pp_t pp;
        pp.hh = OPND_W'(a[OPND_W-1:SPLIT_W]) * OPND_W'(b[OPND_W-1:SPLIT_W]);
        pp.hl = OPND_W'(a[OPND_W-1:SPLIT_W]) * OPND_W'(b[SPLIT_W-1:0]);
        pp.lh = OPND_W'(a[SPLIT_W-1:0]) * OPND_W'(b[OPND_W-1:SPLIT_W]);
        pp.ll = OPND_W'(a[SPLIT_W-1:0]) * OPND_W'(b[SPLIT_W-1:0]);
        return pp;
    endfunction

    function automatic logic [WIDE_W-1:0] pp_join(input lsnh_pp_t pp);
        logic [WIDE_W-1:0] mid;
        mid = WIDE_W'(pp.hl) + WIDE_W'(pp.lh);
        return (WIDE_W'(pp.hh) << OPND_W) + (mid << SPLIT_W) + WIDE_W'(pp.ll);
    endfunction

endpackage

FILE: src/line_sphere_nearest_hit.sv
// Top level of the nearest line-sphere hit distance block.
//
//   Channel   Ports                          Carries
//   input     s_valid, s_ready, s_data       two line points (lsnh_in_t)
//   result    m_valid, m_ready, m_data       nearest distance and miss flag (lsnh_out_t)
//   config    cfg_valid, cfg_ready, cfg_*    sphere center and radius registers
//
// One transfer is accepted per cycle while the input skid register is empty.
// The pipeline holds the 51 cells of the square root chain and the 24 cells of the
// distance chain. The whole pipeline advances together while the result register is
// empty or being taken; an input skid register keeps one transfer during a stall.
// Reset is synchronous and clears all valid bits and the configuration registers.
`timescale 1ns / 1ps
module line_sphere_nearest_hit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  lsnh_pkg::lsnh_in_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output lsnh_pkg::lsnh_out_t                m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lsnh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lsnh_pkg::COORD_W-1:0]       cfg_data
);
    import lsnh_pkg::*;

    logic signed [COORD_W-1:0] center_x_reg, center_y_reg, center_z_reg;
    logic [R_W-1:0]            radius_reg;

    logic       en;
    logic       skid_valid_reg;
    lsnh_in_t   skid_data_reg;
    logic       front_valid;
    lsnh_in_t   front_data;

    lsnh_sqrt_t sq_chain [0:ROOT_W];
    lsnh_dist_t ds_chain [0:DIST_W];

    logic              na_valid_reg, nb_valid_reg;
    logic              na_no_hit_reg, nb_no_hit_reg;
    logic [SQ_W-1:0]   na_bsq_reg, nb_bsq_reg;
    logic [ROOT_W-1:0] n_reg;
    lsnh_pp_t          npp_reg;
    lsnh_dist_t        nc_reg;

    logic              m_valid_reg;
    lsnh_out_t         m_data_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
            radius_reg   <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CENTER_X: center_x_reg <= cfg_data;
                REG_CENTER_Y: center_y_reg <= cfg_data;
                REG_CENTER_Z: center_z_reg <= cfg_data;
                REG_RADIUS:   radius_reg   <= cfg_data[R_W-1:0];
                default: ;
            endcase
        end
    end

    assign en          = !m_valid_reg || m_ready;
    assign s_ready     = !skid_valid_reg;
    assign front_valid = skid_valid_reg || (s_valid && s_ready);
    assign front_data  = skid_valid_reg ? skid_data_reg : s_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else if (en) begin
            skid_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!en && s_valid && s_ready) begin
            skid_data_reg <= s_data;
        end
    end

    lsnh_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (front_valid),
        .in_data  (front_data),
        .center_x (center_x_reg),
        .center_y (center_y_reg),
        .center_z (center_z_reg),
        .radius   (radius_reg),
        .out_data (sq_chain[0])
    );

    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        lsnh_sqrt_cell #(.STEP(k)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .cell_in  (sq_chain[k]),
            .cell_out (sq_chain[k+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            na_valid_reg <= 1'b0;
            nb_valid_reg <= 1'b0;
            nc_reg.valid <= 1'b0;
        end else if (en) begin
            na_valid_reg <= sq_chain[ROOT_W].valid;
            nb_valid_reg <= na_valid_reg;
            nc_reg.valid <= nb_valid_reg;
        end
        if (en) begin
            n_reg         <= (ROOT_W'(sq_chain[ROOT_W].babs) >= sq_chain[ROOT_W].root)
                           ? ROOT_W'(sq_chain[ROOT_W].babs) - sq_chain[ROOT_W].root
                           : sq_chain[ROOT_W].root - ROOT_W'(sq_chain[ROOT_W].babs);
            na_no_hit_reg <= sq_chain[ROOT_W].no_hit;
            na_bsq_reg    <= sq_chain[ROOT_W].bsq;

            npp_reg       <= pp_split(OPND_W'(n_reg), OPND_W'(n_reg));
            nb_no_hit_reg <= na_no_hit_reg;
            nb_bsq_reg    <= na_bsq_reg;

            nc_reg.no_hit <= nb_no_hit_reg;
            nc_reg.bsq    <= nb_bsq_reg;
            nc_reg.nsq    <= NSQ_W'(pp_join(npp_reg));
            nc_reg.p      <= '0;
            nc_reg.q      <= '0;
            nc_reg.r      <= '0;
        end
    end

    always_comb begin
        ds_chain[0] = nc_reg;
    end

    for (genvar j = 0; j < DIST_W; j++) begin : g_dist
        lsnh_dist_cell #(.BIT(DIST_W - 1 - j)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .cell_in  (ds_chain[j]),
            .cell_out (ds_chain[j+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= ds_chain[DIST_W].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg.near_distance <= ds_chain[DIST_W].no_hit ? '0 : ds_chain[DIST_W].r;
            m_data_reg.no_hit        <= ds_chain[DIST_W].no_hit;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && skid_valid_reg) |=> !skid_valid_reg)
        else $error("skid register kept its transfer while the pipeline advanced");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.no_hit) |-> (m_data.near_distance == '0))
        else $error("miss result carries a nonzero distance");

    a_root_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_chain[ROOT_W].valid |->
            (sq_chain[ROOT_W].rem <= {1'b0, sq_chain[ROOT_W].root, 1'b0}))
        else $error("square root remainder exceeds twice the root");

endmodule

FILE: src/lsnh_front.sv
// Front pipeline: differences, dot products, wide products and the discriminant.
`timescale 1ns / 1ps
module lsnh_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  lsnh_pkg::lsnh_in_t              in_data,
    input  logic signed [lsnh_pkg::COORD_W-1:0] center_x,
    input  logic signed [lsnh_pkg::COORD_W-1:0] center_y,
    input  logic signed [lsnh_pkg::COORD_W-1:0] center_z,
    input  logic [lsnh_pkg::R_W-1:0]        radius,
    output lsnh_pkg::lsnh_sqrt_t            out_data
);
    import lsnh_pkg::*;

    logic [5:1] valid_reg;

    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dz_reg, wx_reg, wy_reg, wz_reg;
    logic [R_W-1:0]           rad_reg;

    logic signed [PROD_W-1:0] dxx_reg, dyy_reg, dzz_reg, wxx_reg, wyy_reg, wzz_reg;
    logic signed [PROD_W-1:0] wdx_reg, wdy_reg, wdz_reg;
    logic [R2_W-1:0]          r2_reg;

    logic signed [DOT_W-1:0] bsum, asum, bdot;
    logic [SQ_W-1:0]         bsq3_reg, asq3_reg, babs3_reg;
    logic [R2_W-1:0]         r23_reg;
    logic                    zero3_reg;

    lsnh_pp_t        ppb_reg, ppr_reg, ppa_reg;
    logic [SQ_W-1:0] bsq4_reg, babs4_reg;
    logic            zero4_reg;

    logic [WIDE_W-1:0] bb_reg, br_reg, ba_reg;
    logic [SQ_W-1:0]   bsq5_reg, babs5_reg;
    logic              zero5_reg;

    logic [WIDE_W-1:0] plus;
    logic              miss;
    lsnh_sqrt_t        out_next, out_reg;

    assign bsum = DOT_W'(dxx_reg) + DOT_W'(dyy_reg) + DOT_W'(dzz_reg);
    assign asum = DOT_W'(wxx_reg) + DOT_W'(wyy_reg) + DOT_W'(wzz_reg);
    assign bdot = DOT_W'(wdx_reg) + DOT_W'(wdy_reg) + DOT_W'(wdz_reg);

    assign plus = bb_reg + br_reg;
    assign miss = zero5_reg || (ba_reg > plus);

    always_comb begin
        out_next.valid  = valid_reg[5];
        out_next.no_hit = miss;
        out_next.babs   = babs5_reg;
        out_next.bsq    = bsq5_reg;
        out_next.disc   = miss ? '0 : DISC_W'(plus - ba_reg);
        out_next.rem    = '0;
        out_next.root   = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            out_reg.valid <= 1'b0;
        end else if (en) begin
            valid_reg     <= {valid_reg[4:1], in_valid};
            out_reg.valid <= out_next.valid;
        end
        if (en) begin
            dx_reg  <= DIFF_W'(in_data.end_x) - DIFF_W'(in_data.start_x);
            dy_reg  <= DIFF_W'(in_data.end_y) - DIFF_W'(in_data.start_y);
            dz_reg  <= DIFF_W'(in_data.end_z) - DIFF_W'(in_data.start_z);
            wx_reg  <= DIFF_W'(in_data.start_x) - DIFF_W'(center_x);
            wy_reg  <= DIFF_W'(in_data.start_y) - DIFF_W'(center_y);
            wz_reg  <= DIFF_W'(in_data.start_z) - DIFF_W'(center_z);
            rad_reg <= radius;

            dxx_reg <= PROD_W'(dx_reg) * PROD_W'(dx_reg);
            dyy_reg <= PROD_W'(dy_reg) * PROD_W'(dy_reg);
            dzz_reg <= PROD_W'(dz_reg) * PROD_W'(dz_reg);
            wxx_reg <= PROD_W'(wx_reg) * PROD_W'(wx_reg);
            wyy_reg <= PROD_W'(wy_reg) * PROD_W'(wy_reg);
            wzz_reg <= PROD_W'(wz_reg) * PROD_W'(wz_reg);
            wdx_reg <= PROD_W'(wx_reg) * PROD_W'(dx_reg);
            wdy_reg <= PROD_W'(wy_reg) * PROD_W'(dy_reg);
            wdz_reg <= PROD_W'(wz_reg) * PROD_W'(dz_reg);
            r2_reg  <= R2_W'(rad_reg) * R2_W'(rad_reg);

            bsq3_reg  <= bsum[SQ_W-1:0];
            asq3_reg  <= asum[SQ_W-1:0];
            babs3_reg <= bdot[DOT_W-1] ? SQ_W'(-bdot) : bdot[SQ_W-1:0];
            r23_reg   <= r2_reg;
            zero3_reg <= (bsum == '0);

            ppb_reg   <= pp_split(OPND_W'(babs3_reg), OPND_W'(babs3_reg));
            ppr_reg   <= pp_split(OPND_W'(bsq3_reg), OPND_W'(r23_reg));
            ppa_reg   <= pp_split(OPND_W'(bsq3_reg), OPND_W'(asq3_reg));
            bsq4_reg  <= bsq3_reg;
            babs4_reg <= babs3_reg;
            zero4_reg <= zero3_reg;

            bb_reg    <= pp_join(ppb_reg);
            br_reg    <= pp_join(ppr_reg);
            ba_reg    <= pp_join(ppa_reg);
            bsq5_reg  <= bsq4_reg;
            babs5_reg <= babs4_reg;
            zero5_reg <= zero4_reg;

            out_reg.no_hit <= out_next.no_hit;
            out_reg.babs   <= out_next.babs;
            out_reg.bsq    <= out_next.bsq;
            out_reg.disc   <= out_next.disc;
            out_reg.rem    <= out_next.rem;
            out_reg.root   <= out_next.root;
        end
    end

    assign out_data = out_reg;

endmodule

FILE: src/lsnh_sqrt_cell.sv
// One cell of the square root chain: settles one root bit from one pair of radicand bits.
`timescale 1ns / 1ps
module lsnh_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  lsnh_pkg::lsnh_sqrt_t cell_in,
    output lsnh_pkg::lsnh_sqrt_t cell_out
);
    import lsnh_pkg::*;

    logic [1:0]       pair;
    logic [REM_W+1:0] acc, trial;
    logic             ge;
    lsnh_sqrt_t       cell_next, cell_reg;

    assign pair  = cell_in.disc[DISC_W-1-2*STEP -: 2];
    assign acc   = {cell_in.rem, pair};
    assign trial = {2'b00, cell_in.root, 2'b01};
    assign ge    = (acc >= trial);

    always_comb begin
        cell_next      = cell_in;
        cell_next.rem  = ge ? REM_W'(acc - trial) : REM_W'(acc);
        cell_next.root = {cell_in.root[ROOT_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            cell_reg.valid <= cell_next.valid;
        end
        if (en) begin
            cell_reg.no_hit <= cell_next.no_hit;
            cell_reg.babs   <= cell_next.babs;
            cell_reg.bsq    <= cell_next.bsq;
            cell_reg.disc   <= cell_next.disc;
            cell_reg.rem    <= cell_next.rem;
            cell_reg.root   <= cell_next.root;
        end
    end

    assign cell_out = cell_reg;

endmodule

FILE: src/lsnh_dist_cell.sv
// One cell of the distance chain: decides one distance bit by testing r*r*B against n*n.
`timescale 1ns / 1ps
module lsnh_dist_cell #(
    parameter int BIT = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  lsnh_pkg::lsnh_dist_t cell_in,
    output lsnh_pkg::lsnh_dist_t cell_out
);
    import lsnh_pkg::*;

    logic [P_W-1:0] cand;
    logic           take;
    lsnh_dist_t     cell_next, cell_reg;

    // (r + 2^k)^2 * B = r^2*B + 2^(k+1) * r*B + 2^(2k) * B
    assign cand = cell_in.p + (P_W'(cell_in.q) << (BIT + 1)) + (P_W'(cell_in.bsq) << (2 * BIT));
    assign take = (cand <= P_W'(cell_in.nsq));

    always_comb begin
        cell_next = cell_in;
        if (take) begin
            cell_next.p      = cand;
            cell_next.q      = cell_in.q + (Q_W'(cell_in.bsq) << BIT);
            cell_next.r[BIT] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            cell_reg.valid <= cell_next.valid;
        end
        if (en) begin
            cell_reg.no_hit <= cell_next.no_hit;
            cell_reg.bsq    <= cell_next.bsq;
            cell_reg.nsq    <= cell_next.nsq;
            cell_reg.p      <= cell_next.p;
            cell_reg.q      <= cell_next.q;
            cell_reg.r      <= cell_next.r;
        end
    end

    assign cell_out = cell_reg;

endmodule

FILE: sim/line_sphere_nearest_hit_checker.sv
// Checker that predicts the nearest sphere hit distance of each transfer and compares results.
`timescale 1ns / 1ps
module line_sphere_nearest_hit_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  lsnh_pkg::lsnh_in_t             s_data,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  lsnh_pkg::lsnh_out_t            m_data,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [lsnh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lsnh_pkg::COORD_W-1:0]   cfg_data,
    output int                             fail_count,
    output int                             pending_count,
    output int                             hit_count,
    output int                             miss_count
);
    import lsnh_pkg::*;

    logic signed [COORD_W-1:0] sphere_cx;
    logic signed [COORD_W-1:0] sphere_cy;
    logic signed [COORD_W-1:0] sphere_cz;
    logic [R_W-1:0]            sphere_r;
    lsnh_out_t                 expected_hits[$];

    function automatic lsnh_out_t nearest_hit(input lsnh_in_t seg);
        longint    dx, dy, dz, wx, wy, wz, dot;
        logic [127:0] bsq, asq, babs, r2, plus, minus, disc, root, n, nsq, c;
        lsnh_out_t res;
        dx = longint'(seg.end_x) - longint'(seg.start_x);
        dy = longint'(seg.end_y) - longint'(seg.start_y);
        dz = longint'(seg.end_z) - longint'(seg.start_z);
        wx = longint'(seg.start_x) - longint'(sphere_cx);
        wy = longint'(seg.start_y) - longint'(sphere_cy);
        wz = longint'(seg.start_z) - longint'(sphere_cz);
        bsq = 128'(dx * dx + dy * dy + dz * dz);
        asq = 128'(wx * wx + wy * wy + wz * wz);
        dot = wx * dx + wy * dy + wz * dz;
        babs = (dot < 0) ? 128'(-dot) : 128'(dot);
        r2 = 128'(sphere_r) * 128'(sphere_r);
        res.near_distance = '0;
        res.no_hit = 1'b1;
        if (bsq == 0) begin
            return res;
        end
        plus = babs * babs + bsq * r2;
        minus = bsq * asq;
        if (minus > plus) begin
            return res;
        end
        disc = plus - minus;
        root = '0;
        for (int i = 52; i >= 0; i--) begin
            c = root | (128'(1) << i);
            if (c * c <= disc) begin
                root = c;
            end
        end
        n = (babs >= root) ? babs - root : root - babs;
        nsq = n * n;
        root = '0;
        for (int i = 23; i >= 0; i--) begin
            c = root | (128'(1) << i);
            if (c * c * bsq <= nsq) begin
                root = c;
            end
        end
        res.near_distance = root[DIST_W-1:0];
        res.no_hit = 1'b0;
        return res;
    endfunction

    assign pending_count = expected_hits.size();

    always @(posedge aclk) begin
        lsnh_out_t want;
        if (!aresetn) begin
            sphere_cx <= '0;
            sphere_cy <= '0;
            sphere_cz <= '0;
            sphere_r <= '0;
            expected_hits.delete();
            fail_count <= 0;
            hit_count <= 0;
            miss_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CENTER_X: sphere_cx <= cfg_data;
                    REG_CENTER_Y: sphere_cy <= cfg_data;
                    REG_CENTER_Z: sphere_cz <= cfg_data;
                    REG_RADIUS:   sphere_r <= cfg_data[R_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                expected_hits.push_back(nearest_hit(s_data));
            end
            if (m_valid && m_ready) begin
                if (expected_hits.size() == 0) begin
                    $display("%0t: unexpected result distance=%0d no_hit=%0b", $time,
                             m_data.near_distance, m_data.no_hit);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_hits.pop_front();
                    if (want.no_hit) begin
                        miss_count <= miss_count + 1;
                    end else begin
                        hit_count <= hit_count + 1;
                    end
                    if (want.near_distance !== m_data.near_distance) begin
                        $display("%0t: near_distance expected %0d actual %0d", $time,
                                 want.near_distance, m_data.near_distance);
                        fail_count <= fail_count + 1;
                    end else if (want.no_hit !== m_data.no_hit) begin
                        $display("%0t: no_hit expected %0b actual %0b", $time,
                                 want.no_hit, m_data.no_hit);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: sim/line_sphere_nearest_hit_test.sv
// Testbench top that drives line segments and sphere settings into the nearest hit block.
`timescale 1ns / 1ps
module line_sphere_nearest_hit_test;
    import lsnh_pkg::*;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    lsnh_in_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    lsnh_out_t            m_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COORD_W-1:0]   cfg_data;
    int                   fail_count;
    int                   pending_count;
    int                   hit_count;
    int                   miss_count;
    int                   send_idle_pct;
    int                   recv_idle_pct;
    int                   sent_count;
    logic signed [COORD_W-1:0] cur_cx, cur_cy, cur_cz;
    int                   cur_r;

    line_sphere_nearest_hit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    line_sphere_nearest_hit_checker checker_inst (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_count(pending_count),
        .hit_count(hit_count), .miss_count(miss_count)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("Timeout with %0d results outstanding.", pending_count);
        $display("== FAIL ==");
        $finish;
    end

    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_segment(input lsnh_in_t seg);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data = seg;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid = 1'b0;
        sent_count++;
    endtask

    task automatic drain();
        while (pending_count != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_sphere(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                              input logic [COORD_W-1:0] cz, input int r);
        drain();
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_RADIUS, COORD_W'(r));
        write_reg(REG_RADIUS + 3'(1 + $urandom_range(0, 3)), COORD_W'($urandom));
        cur_cx = cx;
        cur_cy = cy;
        cur_cz = cz;
        cur_r = r;
    endtask

    function automatic lsnh_in_t seg_of(input int ax, input int ay, input int az,
                                        input int bx, input int by, input int bz);
        lsnh_in_t seg;
        seg.start_x = COORD_W'(ax);
        seg.start_y = COORD_W'(ay);
        seg.start_z = COORD_W'(az);
        seg.end_x = COORD_W'(bx);
        seg.end_y = COORD_W'(by);
        seg.end_z = COORD_W'(bz);
        return seg;
    endfunction

    function automatic int near_coord(input logic signed [COORD_W-1:0] ctr, input int span);
        return int'(ctr) + $urandom_range(0, 2 * span) - span;
    endfunction

    task automatic random_segment();
        lsnh_in_t seg;
        int       span;
        if ($urandom_range(99) < 25) begin
            seg = lsnh_in_t'($bits(lsnh_in_t)'({$urandom, $urandom, $urandom, $urandom,
                                                $urandom}));
        end else begin
            span = 2 * cur_r + $urandom_range(0, 4096) + 1;
            if ($urandom_range(3) == 0) begin
                span = $urandom_range(1, 64);
            end
            seg = seg_of(near_coord(cur_cx, span), near_coord(cur_cy, span),
                         near_coord(cur_cz, span), near_coord(cur_cx, span),
                         near_coord(cur_cy, span), near_coord(cur_cz, span));
            if ($urandom_range(19) == 0) begin
                seg.end_x = seg.start_x;
                seg.end_y = seg.start_y;
                seg.end_z = seg.start_z;
            end
        end
        send_segment(seg);
    endtask

    initial begin
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_CENTER_X;
        cfg_data = '0;
        m_ready = 1'b0;
        send_idle_pct = 27;
        recv_idle_pct = 86;
        sent_count = 0;
        cur_cx = '0;
        cur_cy = '0;
        cur_cz = '0;
        cur_r = 0;
        aresetn = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset sphere of zero radius: only lines through the origin touch it.
        send_segment(seg_of(-100, 0, 0, 100, 0, 0));
        send_segment(seg_of(-100, 5, 0, 100, 5, 0));
        send_segment(seg_of(7, 7, 7, 7, 7, 7));
        set_sphere(COORD_W'(0), COORD_W'(0), COORD_W'(0), 1024);
        send_segment(seg_of(-4096, 1024, 0, 4096, 1024, 0));
        send_segment(seg_of(-4096, 2000, 0, 4096, 2000, 0));
        send_segment(seg_of(-4096, 0, 0, 4096, 0, 0));
        send_segment(seg_of(0, 0, 0, 0, 0, 3000));
        send_segment(seg_of(4096, 0, 0, 8192, 0, 0));
        send_segment(seg_of(500, 500, 500, 500, 500, 500));
        set_sphere(COORD_W'(0), COORD_W'(0), COORD_W'(0), 4194303);
        send_segment(seg_of(-8388608, 0, 0, -8388607, 0, 0));
        send_segment(seg_of(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607));
        send_segment(seg_of(8388607, 8388607, 8388607, -8388608, -8388608, -8388608));
        send_segment(seg_of(-8388608, 8388607, -8388608, 8388607, -8388608, 8388607));
        set_sphere(COORD_W'(8388607), COORD_W'(8388607), COORD_W'(8388607), 0);
        send_segment(seg_of(-8388608, -8388608, -8388608, 0, 0, 0));
        send_segment(seg_of(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607));
        set_sphere(COORD_W'(-8388608), COORD_W'(-8388608), COORD_W'(-8388608), 4194303);
        send_segment(seg_of(8388607, 8388607, 8388607, 0, 0, 0));
        send_segment(seg_of(-8388608, -8388608, -8388608, -8388608, -8388608, 0));

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 86 : 0;
            recv_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 27 : 0;
            for (int grp = 0; grp < 4; grp++) begin
                set_sphere(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                           (grp == 0) ? $urandom_range(0, 64)
                                      : (grp == 3) ? $urandom_range(4194000, 4194303)
                                                   : $urandom_range(0, 200000));
                for (int k = 0; k < 150; k++) begin
                    random_segment();
                    if (phase == 1 && grp == 1 && k == 75) begin
                        while (pending_count != 0) @(negedge aclk);
                    end
                end
            end
        end

        drain();
        $display("Sent %0d segments across 3 flow-control phases and 17 sphere settings.",
                 sent_count);
        $display("Checked %0d hits and %0d misses.", hit_count, miss_count);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
